// File: sv/sha1bsh_pkg.sv
// ----------------------------------------------------------------------------
// sha1bsh_pkg
// Types, codes and constants shared by the SHA-1 byte stream hasher modules.
// ----------------------------------------------------------------------------
package sha1bsh_pkg;

   localparam int WORD_W  = 32;
   localparam int BLOCK_W = 512;
   localparam int ROUND_W = 7;

   localparam logic [WORD_W-1:0] H0_INIT = 32'h6745_2301;
   localparam logic [WORD_W-1:0] H1_INIT = 32'hEFCD_AB89;
   localparam logic [WORD_W-1:0] H2_INIT = 32'h98BA_DCFE;
   localparam logic [WORD_W-1:0] H3_INIT = 32'h1032_5476;
   localparam logic [WORD_W-1:0] H4_INIT = 32'hC3D2_E1F0;

   localparam logic [WORD_W-1:0] K0 = 32'h5A82_7999;
   localparam logic [WORD_W-1:0] K1 = 32'h6ED9_EBA1;
   localparam logic [WORD_W-1:0] K2 = 32'h8F1B_BCDC;
   localparam logic [WORD_W-1:0] K3 = 32'hCA62_C1D6;

   localparam logic [7:0]         PAD_BYTE   = 8'h80;
   localparam logic [5:0]         BLOCK_LAST = 6'd63;  // byte slot that completes a block
   localparam logic [5:0]         LEN_PREV   = 6'd55;  // slot just before the length field
   localparam logic [ROUND_W-1:0] ROUND_LAST = 7'd79;
   localparam logic [ROUND_W-1:0] ROUND_20   = 7'd20;
   localparam logic [ROUND_W-1:0] ROUND_40   = 7'd40;
   localparam logic [ROUND_W-1:0] ROUND_60   = 7'd60;
   localparam logic [2:0]         WORD_LAST  = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD80,
      ST_PADZ,
      ST_PADLEN,
      ST_ROUND,
      ST_UPDATE,
      ST_EMIT
   } ctrl_state_type;

   typedef enum logic [1:0] {
      BSEL_DATA,
      BSEL_PAD,
      BSEL_ZERO,
      BSEL_LEN
   } byte_sel_type;

   typedef struct packed {
      logic         shift_en;    // push one byte into the block register
      byte_sel_type byte_sel;
      logic         len_add;     // count one message byte
      logic         comp_start;  // load working variables, clear round counter
      logic         round_en;
      logic         chain_add;
      logic         emit_shift;  // rotate chaining words towards the output
      logic         reinit;
   } dp_cmd_type;

   typedef struct packed {
      logic [5:0] fill_count;
      logic       round_last;
      logic       word_last;
   } dp_sts_type;

endpackage

// File: sv/sha1_byte_stream_hasher_core.sv
// ----------------------------------------------------------------------------
// sha1_byte_stream_hasher_core
// A data byte is shifted into the block register; the 64th byte of a block
// also starts a compression (80 rounds on one shared round unit plus the
// chaining add). Finish: the finish transaction, then the pad and length bytes
// up to the block end, one compression per padded block (one or two), then
// five digest transactions, H0 first. Synchronous reset restores the initial
// chaining value, zero length and an empty block.
// ----------------------------------------------------------------------------
module sha1_byte_stream_hasher_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);
   import sha1bsh_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   sha1bsh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   sha1bsh_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_data_byte   (req_data_byte),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word)
   );

   // no new transaction is taken while a digest is going out
   a_no_intake_during_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input accepted while digest pending");

   a_word_sequence: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_word) |=>
         (rsp_valid && (rsp_word_index == ($past(rsp_word_index) + 3'd1))))
      else $error("digest words out of sequence");

   a_finish_blocks_intake: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_func) |=> !req_ready)
      else $error("intake open right after finish");

   a_done_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last_word) |=> (!rsp_valid && req_ready))
      else $error("controller not idle after last digest word");

endmodule

// File: sv/sha1bsh_ctrl.sv
// ----------------------------------------------------------------------------
// sha1bsh_ctrl
// Sequencer: byte intake, padding, compression rounds and digest output.
// ----------------------------------------------------------------------------
module sha1bsh_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_func,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output sha1bsh_pkg::dp_cmd_type cmd,
   input  sha1bsh_pkg::dp_sts_type sts
);
   import sha1bsh_pkg::*;

   ctrl_state_type state_ff, state_in;
   ctrl_state_type ret_ff, ret_in;   // where to go once a block is compressed

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      cmd       = '0;
      cmd.byte_sel = BSEL_DATA;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_func) begin
                  state_in = ST_PAD80;
               end else begin
                  cmd.shift_en = 1'b1;
                  cmd.len_add  = 1'b1;
                  if (sts.fill_count == BLOCK_LAST) begin
                     cmd.comp_start = 1'b1;
                     ret_in         = ST_IDLE;
                     state_in       = ST_ROUND;
                  end
               end
            end
         end
         ST_PAD80: begin
            cmd.shift_en = 1'b1;
            cmd.byte_sel = BSEL_PAD;
            if (sts.fill_count == BLOCK_LAST) begin
               cmd.comp_start = 1'b1;
               ret_in         = ST_PADZ;
               state_in       = ST_ROUND;
            end else if (sts.fill_count == LEN_PREV) begin
               state_in = ST_PADLEN;
            end else begin
               state_in = ST_PADZ;
            end
         end
         ST_PADZ: begin
            cmd.shift_en = 1'b1;
            cmd.byte_sel = BSEL_ZERO;
            if (sts.fill_count == BLOCK_LAST) begin
               cmd.comp_start = 1'b1;
               ret_in         = ST_PADZ;
               state_in       = ST_ROUND;
            end else if (sts.fill_count == LEN_PREV) begin
               state_in = ST_PADLEN;
            end
         end
         ST_PADLEN: begin
            cmd.shift_en = 1'b1;
            cmd.byte_sel = BSEL_LEN;
            if (sts.fill_count == BLOCK_LAST) begin
               cmd.comp_start = 1'b1;
               ret_in         = ST_EMIT;
               state_in       = ST_ROUND;
            end
         end
         ST_ROUND: begin
            cmd.round_en = 1'b1;
            if (sts.round_last) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.chain_add = 1'b1;
            state_in      = ret_ff;
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.emit_shift = 1'b1;
               if (sts.word_last) begin
                  cmd.reinit = 1'b1;
                  state_in   = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: sv/sha1bsh_dp.sv
// ----------------------------------------------------------------------------
// sha1bsh_dp
// Block register doubling as the message schedule window, round logic,
// chaining value, bit length and output word selection.
// ----------------------------------------------------------------------------
module sha1bsh_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [7:0]              req_data_byte,
   input  sha1bsh_pkg::dp_cmd_type cmd,
   output sha1bsh_pkg::dp_sts_type sts,
   output logic [31:0]             rsp_digest_word,
   output logic [2:0]              rsp_word_index,
   output logic                    rsp_last_word
);
   import sha1bsh_pkg::*;

   logic [BLOCK_W-1:0] blk_ff, blk_in;
   logic [WORD_W-1:0]  h_ff [0:4];
   logic [WORD_W-1:0]  h_in [0:4];
   logic [WORD_W-1:0]  a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [WORD_W-1:0]  a_in, b_in, c_in, d_in, e_in;
   logic [ROUND_W-1:0] round_ff, round_in;
   logic [5:0]         fill_ff, fill_in;
   logic [63:0]        len_ff, len_in;
   logic [2:0]         widx_ff, widx_in;

   logic [7:0]         byte_val;
   logic [WORD_W-1:0]  w_cur, w_mix, w_new, f_val, k_val, t_val;

   // oldest schedule word sits at the top of the block register
   assign w_cur = blk_ff[511:480];
   assign w_mix = blk_ff[511:480] ^ blk_ff[447:416] ^ blk_ff[255:224] ^ blk_ff[95:64];
   assign w_new = {w_mix[30:0], w_mix[31]};

   always_comb begin
      if (round_ff < ROUND_20) begin
         f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         k_val = K0;
      end else if (round_ff < ROUND_40) begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = K1;
      end else if (round_ff < ROUND_60) begin
         f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k_val = K2;
      end else begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = K3;
      end
   end

   assign t_val = {a_ff[26:0], a_ff[31:27]} + f_val + e_ff + w_cur + k_val;

   always_comb begin
      case (cmd.byte_sel)
         BSEL_DATA: byte_val = req_data_byte;
         BSEL_PAD:  byte_val = PAD_BYTE;
         BSEL_ZERO: byte_val = 8'h00;
         // length goes out most significant byte first, slots 56..63
         BSEL_LEN:  byte_val = len_ff[{~fill_ff[2:0], 3'b000} +: 8];
         default:   byte_val = 8'h00;
      endcase
   end

   always_comb begin
      blk_in   = blk_ff;
      fill_in  = fill_ff;
      len_in   = len_ff;
      round_in = round_ff;
      widx_in  = widx_ff;
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      e_in = e_ff;
      for (int i = 0; i < 5; i++) begin
         h_in[i] = h_ff[i];
      end

      if (cmd.shift_en) begin
         blk_in  = {blk_ff[BLOCK_W-9:0], byte_val};
         fill_in = fill_ff + 6'd1;
      end
      if (cmd.len_add) begin
         len_in = len_ff + 64'd8;
      end
      if (cmd.comp_start) begin
         round_in = '0;
         a_in = h_ff[0];
         b_in = h_ff[1];
         c_in = h_ff[2];
         d_in = h_ff[3];
         e_in = h_ff[4];
      end
      if (cmd.round_en) begin
         blk_in   = {blk_ff[BLOCK_W-33:0], w_new};
         round_in = round_ff + 7'd1;
         a_in = t_val;
         b_in = a_ff;
         c_in = {b_ff[1:0], b_ff[31:2]};
         d_in = c_ff;
         e_in = d_ff;
      end
      if (cmd.chain_add) begin
         h_in[0] = h_ff[0] + a_ff;
         h_in[1] = h_ff[1] + b_ff;
         h_in[2] = h_ff[2] + c_ff;
         h_in[3] = h_ff[3] + d_ff;
         h_in[4] = h_ff[4] + e_ff;
      end
      if (cmd.emit_shift) begin
         h_in[0] = h_ff[1];
         h_in[1] = h_ff[2];
         h_in[2] = h_ff[3];
         h_in[3] = h_ff[4];
         h_in[4] = h_ff[0];
         widx_in = widx_ff + 3'd1;
      end
      if (cmd.reinit) begin
         h_in[0] = H0_INIT;
         h_in[1] = H1_INIT;
         h_in[2] = H2_INIT;
         h_in[3] = H3_INIT;
         h_in[4] = H4_INIT;
         len_in  = '0;
         fill_in = '0;
         widx_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_ff[0]  <= H0_INIT;
         h_ff[1]  <= H1_INIT;
         h_ff[2]  <= H2_INIT;
         h_ff[3]  <= H3_INIT;
         h_ff[4]  <= H4_INIT;
         fill_ff  <= '0;
         len_ff   <= '0;
         round_ff <= '0;
         widx_ff  <= '0;
      end else begin
         for (int i = 0; i < 5; i++) begin
            h_ff[i] <= h_in[i];
         end
         fill_ff  <= fill_in;
         len_ff   <= len_in;
         round_ff <= round_in;
         widx_ff  <= widx_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      d_ff   <= d_in;
      e_ff   <= e_in;
   end

   assign sts.fill_count = fill_ff;
   assign sts.round_last = (round_ff == ROUND_LAST);
   assign sts.word_last  = (widx_ff == WORD_LAST);

   assign rsp_digest_word = h_ff[0];
   assign rsp_word_index  = widx_ff;
   assign rsp_last_word   = (widx_ff == WORD_LAST);

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives byte and finish transactions into the SHA-1 byte stream hasher,
// predicts each digest with a behavioural SHA-1, and checks every digest word
// in order under random idling, a steady stretch and a long output stall.
// ----------------------------------------------------------------------------
module testbench;
   import sha1bsh_pkg::*;

   localparam logic FUNC_APPEND = 1'b0;
   localparam logic FUNC_FINISH = 1'b1;

   localparam int IDLE_PCT      = 29;
   localparam int STALL_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 200;
   localparam int HOLD_CYCLES   = 400;
   localparam int TARGET_ITEMS  = 430;
   localparam int MAX_PRINTS    = 100;
   localparam int BLOCK_BYTES   = 64;
   localparam int LEN_SLOT      = 56;

   typedef struct {
      logic [31:0] word_value;
      logic [2:0]  word_index;
      logic        last_word;
   } digest_entry_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_func = FUNC_APPEND;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   // predicted hasher state
   logic [31:0] digest_state [5];
   logic [7:0]  pend_block [BLOCK_BYTES];
   int unsigned pend_fill;
   logic [63:0] msg_bit_count;

   digest_entry_type digests_due [$];
   int  mismatch_count = 0;
   int  items_sent     = 0;
   bit  steady         = 1'b0;
   int  hold_serial    = 0;
   int  hold_seen      = 0;
   int  hold_left      = 0;

   always #5 clock = ~clock;

   sha1_byte_stream_hasher_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word)
   );

   function automatic void restart_digest();
      digest_state[0] = H0_INIT;
      digest_state[1] = H1_INIT;
      digest_state[2] = H2_INIT;
      digest_state[3] = H3_INIT;
      digest_state[4] = H4_INIT;
      pend_fill       = 0;
      msg_bit_count   = '0;
   endfunction

   function automatic void compress_pending_block();
      logic [31:0] w [80];
      logic [31:0] a, b, c, d, e, f, k, t;
      int i;
      for (i = 0; i < 16; i++)
         w[i] = {pend_block[4*i], pend_block[4*i+1], pend_block[4*i+2], pend_block[4*i+3]};
      for (i = 16; i < 80; i++) begin
         t    = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
         w[i] = {t[30:0], t[31]};
      end
      a = digest_state[0];
      b = digest_state[1];
      c = digest_state[2];
      d = digest_state[3];
      e = digest_state[4];
      for (i = 0; i < 80; i++) begin
         if (i < 20) begin
            f = (b & c) | (~b & d);
            k = K0;
         end else if (i < 40) begin
            f = b ^ c ^ d;
            k = K1;
         end else if (i < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = K2;
         end else begin
            f = b ^ c ^ d;
            k = K3;
         end
         t = {a[26:0], a[31:27]} + f + e + w[i] + k;
         e = d;
         d = c;
         c = {b[1:0], b[31:2]};
         b = a;
         a = t;
      end
      digest_state[0] += a;
      digest_state[1] += b;
      digest_state[2] += c;
      digest_state[3] += d;
      digest_state[4] += e;
      pend_fill = 0;
   endfunction

   // Updates the predicted state for one accepted transaction; a finish queues
   // the five digest words.
   function automatic void hasher_predict(logic func, logic [7:0] data);
      int unsigned      pos;
      int               k;
      digest_entry_type ent;
      if (func == FUNC_APPEND) begin
         msg_bit_count += 64'd8;
         pend_block[pend_fill] = data;
         pend_fill++;
         if (pend_fill == BLOCK_BYTES)
            compress_pending_block();
      end else begin
         pos = pend_fill;
         pend_block[pos] = PAD_BYTE;
         pos++;
         // no room left for the length: pad out and spill into a second block
         if (pos > LEN_SLOT) begin
            while (pos < BLOCK_BYTES) begin
               pend_block[pos] = 8'h00;
               pos++;
            end
            compress_pending_block();
            pos = 0;
         end
         while (pos < LEN_SLOT) begin
            pend_block[pos] = 8'h00;
            pos++;
         end
         for (k = 0; k < 8; k++)
            pend_block[LEN_SLOT + k] = msg_bit_count[63 - 8*k -: 8];
         compress_pending_block();
         for (k = 0; k < 5; k++) begin
            ent.word_value = digest_state[k];
            ent.word_index = k[2:0];
            ent.last_word  = (k[2:0] == WORD_LAST);
            digests_due.push_back(ent);
         end
         restart_digest();
      end
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTS)
         $display("%0t ns: %s", $time, what);
   endtask

   // One request transaction: random idle cycles first, then hold valid until taken.
   task automatic send_item(input logic func, input logic [7:0] data);
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_func      <= func;
      req_data_byte <= data;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      hasher_predict(func, data);
      items_sent++;
   endtask

   task automatic random_message(input int len);
      int i;
      for (i = 0; i < len; i++)
         send_item(FUNC_APPEND, 8'($urandom_range(0, 255)));
      send_item(FUNC_FINISH, 8'($urandom_range(0, 255)));
   endtask

   task automatic test_empty_message();
      send_item(FUNC_FINISH, 8'h00);
   endtask

   task automatic test_byte_extremes();
      send_item(FUNC_APPEND, 8'h00);
      send_item(FUNC_FINISH, 8'hFF);
      send_item(FUNC_APPEND, 8'hFF);
      send_item(FUNC_FINISH, 8'h00);
      send_item(FUNC_APPEND, PAD_BYTE);
      send_item(FUNC_FINISH, 8'h55);
      send_item(FUNC_APPEND, 8'h61);
      send_item(FUNC_APPEND, 8'h62);
      send_item(FUNC_APPEND, 8'h63);
      send_item(FUNC_FINISH, 8'hAA);
   endtask

   // 55 fits the length in one block; 56 and 63 need the extra block;
   // 64 completes a block before the finish.
   task automatic test_block_boundaries();
      random_message(55);
      random_message(56);
      random_message(63);
      random_message(64);
   endtask

   task automatic test_back_to_back();
      steady = 1'b1;
      random_message($urandom_range(1, 20));
      random_message(0);
      random_message($urandom_range(1, 20));
      steady = 1'b0;
   endtask

   task automatic test_output_backpressure();
      hold_serial++;
      random_message($urandom_range(5, 40));
      random_message($urandom_range(5, 40));
      random_message($urandom_range(5, 40));
   endtask

   task automatic test_random_messages();
      while (items_sent < TARGET_ITEMS) begin
         if ($urandom_range(0, 99) < 75)
            random_message($urandom_range(0, 12));
         else
            random_message($urandom_range(40, 70));
      end
   endtask

   // receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_serial != hold_seen) begin
         hold_seen = hold_serial;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      digest_entry_type ent;
      if (!reset && rsp_valid && rsp_ready) begin
         if (digests_due.size() == 0) begin
            report_mismatch($sformatf("unexpected digest word %08h index %0d",
                                      rsp_digest_word, rsp_word_index));
         end else begin
            ent = digests_due.pop_front();
            if (rsp_digest_word !== ent.word_value)
               report_mismatch($sformatf("digest word %0d: got %08h, want %08h",
                                         ent.word_index, rsp_digest_word, ent.word_value));
            if (rsp_word_index !== ent.word_index)
               report_mismatch($sformatf("word index: got %0d, want %0d",
                                         rsp_word_index, ent.word_index));
            if (rsp_last_word !== ent.last_word)
               report_mismatch($sformatf("last flag on word %0d: got %b, want %b",
                                         ent.word_index, rsp_last_word, ent.last_word));
         end
      end
   end

   // watchdog on cycles without any transaction
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      restart_digest();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_empty_message();
      test_byte_extremes();
      test_block_boundaries();
      test_back_to_back();
      test_output_backpressure();
      test_random_messages();

      req_valid <= 1'b0;
      while (digests_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
